// ===== src/sample_history_ring_buffer_unit_macros.svh =====
// Assertion macros shared by the sample history ring buffer RTL.
`ifndef SAMPLE_HISTORY_RING_BUFFER_UNIT_MACROS_SVH
`define SAMPLE_HISTORY_RING_BUFFER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SHR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SHR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/shr_pkg.sv =====
// Package: widths, codes and shared types of the sample history ring buffer.
`default_nettype none

package shr_pkg;

    localparam int DEPTH    = 16384;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CAP_W    = 15;
    localparam int SAMPLE_W = 16;
    localparam int MAX_READ = 64;
    localparam int CNT_W    = 7;
    localparam int KIND_W   = 2;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic MOD_ADD = 1'b0;
    localparam logic MOD_SUB = 1'b1;

    typedef struct packed {
        logic              op;
        logic [CAP_W-1:0]  a;
        logic [CAP_W-1:0]  b;
    } mod_req_t;

    typedef struct packed {
        logic                       en;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] data;
    } mem_wr_t;

endpackage

`default_nettype wire

// ===== src/shr_req_if.sv =====
// Interface: request channel (write, read, clear items).
`default_nettype none

interface shr_req_if
    import shr_pkg::*;
    ;
    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [ADDR_W-1:0]          read_offset;
    logic [CNT_W-1:0]           read_count;

    modport source (output valid, output kind, output sample_value,
                    output read_offset, output read_count, input ready);
    modport sink   (input valid, input kind, input sample_value,
                    input read_offset, input read_count, output ready);
endinterface

`default_nettype wire

// ===== src/shr_res_if.sv =====
// Interface: result channel (one item per returned sample, or one marker item for an empty read).
`default_nettype none

interface shr_res_if
    import shr_pkg::*;
    ;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       sample_valid;
    logic [CNT_W-1:0]           granted_count;
    logic [CAP_W-1:0]           fill_level;
    logic                       run_last;

    modport source (output valid, output sample_out, output sample_valid,
                    output granted_count, output fill_level, output run_last,
                    input ready);
    modport sink   (input valid, input sample_out, input sample_valid,
                    input granted_count, input fill_level, input run_last,
                    output ready);
endinterface

`default_nettype wire

// ===== src/sample_history_ring_buffer_unit.sv =====
// Top level: sample history ring buffer with sequencer, shared modulo unit and store.
//
//  channel      dir   handshake      payload
//  request      in    valid/ready    kind, sample_value, read_offset, read_count
//  result       out   valid/ready    sample_out, sample_valid, granted_count,
//                                    fill_level, run_last
//  cfg_wr_*     in    write enable   capacity_used (15 bits)
//
//  Write, clear and unused-kind items are completed in the idle state that accepts them.
//  A read goes through two setup steps in the shared modulo unit, then a fetch and
//  an emit step per sample on the store's read port.
//  A read that returns nothing gives one marker item.
//  A stalled result channel holds the emit step; the output register keeps the
//  last item while the next request is accepted. Reset needs no clearing pass.
`default_nettype none
`include "sample_history_ring_buffer_unit_macros.svh"

module sample_history_ring_buffer_unit
    import shr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    shr_req_if.sink          request,
    shr_res_if.source        result
);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_OLDEST = 3'd1;
    localparam logic [2:0] S_START  = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;
    localparam logic [2:0] S_EMPTY  = 3'd5;

    logic [2:0]        state_reg,  state_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [ADDR_W-1:0] wr_idx_reg, wr_idx_next;
    logic [CAP_W-1:0]  held_reg,   held_next;
    logic [ADDR_W-1:0] ptr_reg,    ptr_next;
    logic [ADDR_W-1:0] offset_reg, offset_next;
    logic [CNT_W-1:0]  grant_reg,  grant_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;

    logic                       res_valid_reg, res_valid_next;
    logic signed [SAMPLE_W-1:0] res_sample_reg, res_sample_next;
    logic                       res_svalid_reg, res_svalid_next;
    logic [CNT_W-1:0]           res_grant_reg, res_grant_next;
    logic [CAP_W-1:0]           res_fill_reg, res_fill_next;
    logic                       res_last_reg, res_last_next;

    logic [CAP_W-1:0]           cap_act;
    logic                       accept;
    logic                       slot_free;
    logic [CNT_W-1:0]           count_clamped;
    logic [CAP_W-1:0]           avail;
    mod_req_t                   mod_req;
    logic [ADDR_W-1:0]          mod_res;
    mem_wr_t                    mem_wr;
    logic                       rd_en;
    logic signed [SAMPLE_W-1:0] rd_data;

    // Capacity of zero acts as one, anything past the store acts as the store size.
    always_comb
    begin
        if (cap_reg == '0)
            cap_act = CAP_W'(1);
        else if (cap_reg > CAP_W'(DEPTH))
            cap_act = CAP_W'(DEPTH);
        else
            cap_act = cap_reg;
    end

    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;
    assign slot_free     = !res_valid_reg || result.ready;

    assign count_clamped = (request.read_count > CNT_W'(MAX_READ)) ?
                           CNT_W'(MAX_READ) : request.read_count;
    assign avail         = held_reg - {1'b0, request.read_offset};

    // Feed the shared modulo unit according to the sequencer step.
    always_comb
    begin
        mod_req.op = MOD_ADD;
        mod_req.a  = {1'b0, wr_idx_reg};
        mod_req.b  = CAP_W'(1);
        case (state_reg)
            S_OLDEST:
            begin
                mod_req.op = MOD_SUB;
                mod_req.a  = {1'b0, wr_idx_reg};
                mod_req.b  = held_reg;
            end
            S_START:
            begin
                mod_req.a = {1'b0, ptr_reg};
                mod_req.b = {1'b0, offset_reg};
            end
            S_FETCH:
            begin
                mod_req.a = {1'b0, ptr_reg};
                mod_req.b = CAP_W'(1);
            end
            default:
            begin
                mod_req.a = {1'b0, wr_idx_reg};
                mod_req.b = CAP_W'(1);
            end
        endcase
    end

    shr_mod_unit u_mod (
        .req (mod_req),
        .cap (cap_act),
        .res (mod_res)
    );

    assign mem_wr.en   = accept && (request.kind == KIND_WRITE);
    assign mem_wr.addr = wr_idx_reg;
    assign mem_wr.data = request.sample_value;
    assign rd_en       = (state_reg == S_FETCH);

    shr_store u_store (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        wr_idx_next     = wr_idx_reg;
        held_next       = held_reg;
        ptr_next        = ptr_reg;
        offset_next     = offset_reg;
        grant_next      = grant_reg;
        remain_next     = remain_reg;
        res_valid_next  = res_valid_reg && !result.ready;
        res_sample_next = res_sample_reg;
        res_svalid_next = res_svalid_reg;
        res_grant_next  = res_grant_reg;
        res_fill_next   = res_fill_reg;
        res_last_next   = res_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (request.kind)
                        KIND_WRITE:
                        begin
                            // Append and advance; fill saturates at capacity.
                            wr_idx_next = mod_res;
                            if (held_reg < cap_act)
                                held_next = held_reg + CAP_W'(1);
                        end
                        KIND_CLEAR:
                        begin
                            wr_idx_next = '0;
                            held_next   = '0;
                        end
                        KIND_READ:
                        begin
                            offset_next = request.read_offset;
                            if (count_clamped == '0 ||
                                {1'b0, request.read_offset} >= held_reg)
                                state_next = S_EMPTY;
                            else
                            begin
                                if (CAP_W'(count_clamped) > avail)
                                    grant_next = avail[CNT_W-1:0];
                                else
                                    grant_next = count_clamped;
                                remain_next = (CAP_W'(count_clamped) > avail) ?
                                              avail[CNT_W-1:0] : count_clamped;
                                state_next  = S_OLDEST;
                            end
                        end
                        default: ; // unused kind: drop
                    endcase
                end
            end
            S_OLDEST:
            begin
                ptr_next   = mod_res;
                state_next = S_START;
            end
            S_START:
            begin
                ptr_next   = mod_res;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                ptr_next   = mod_res;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // Hold until the output register is free.
                if (slot_free)
                begin
                    res_valid_next  = 1'b1;
                    res_sample_next = rd_data;
                    res_svalid_next = 1'b1;
                    res_grant_next  = grant_reg;
                    res_fill_next   = held_reg;
                    res_last_next   = (remain_reg == CNT_W'(1));
                    remain_next     = remain_reg - CNT_W'(1);
                    state_next      = (remain_reg == CNT_W'(1)) ? S_IDLE : S_FETCH;
                end
            end
            S_EMPTY:
            begin
                if (slot_free)
                begin
                    res_valid_next  = 1'b1;
                    res_sample_next = '0;
                    res_svalid_next = 1'b0;
                    res_grant_next  = '0;
                    res_fill_next   = held_reg;
                    res_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // A capacity write empties the history.
        if (cfg_wr_en)
        begin
            wr_idx_next = '0;
            held_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_W'(DEPTH);
            wr_idx_reg    <= '0;
            held_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            held_reg      <= held_next;
            res_valid_reg <= res_valid_next;
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        offset_reg     <= offset_next;
        grant_reg      <= grant_next;
        remain_reg     <= remain_next;
        res_sample_reg <= res_sample_next;
        res_svalid_reg <= res_svalid_next;
        res_grant_reg  <= res_grant_next;
        res_fill_reg   <= res_fill_next;
        res_last_reg   <= res_last_next;
    end

    assign result.valid         = res_valid_reg;
    assign result.sample_out    = res_sample_reg;
    assign result.sample_valid  = res_svalid_reg;
    assign result.granted_count = res_grant_reg;
    assign result.fill_level    = res_fill_reg;
    assign result.run_last      = res_last_reg;

    `SHR_ASSERT_IMPL(a_held_in_range, 1'b1, held_reg <= cap_act, "fill level past capacity")
    `SHR_ASSERT_IMPL(a_widx_in_range, 1'b1, CAP_W'(wr_idx_reg) < cap_act, "write index past capacity")
    `SHR_ASSERT_IMPL(a_empty_marker, res_valid_reg && !res_svalid_reg, res_last_reg && res_grant_reg == '0, "empty read item malformed")
    `SHR_ASSERT_NEXT(a_emit_follows_fetch, state_reg == S_FETCH, state_reg == S_EMIT, "fetch not followed by emit")

endmodule

`default_nettype wire

// ===== src/shr_mod_unit.sv =====
// Shared modular add/subtract unit: result wraps into the range 0 .. cap-1.
`default_nettype none

module shr_mod_unit
    import shr_pkg::*;
(
    input  mod_req_t          req,
    input  logic [CAP_W-1:0]  cap,
    output logic [ADDR_W-1:0] res
);

    logic [CAP_W:0] sum;
    logic [CAP_W:0] diff;
    logic [CAP_W:0] wide;

    // Operands keep a + b below 2*cap and a - b at or above -cap.
    always_comb
    begin
        sum  = {1'b0, req.a} + {1'b0, req.b};
        diff = {1'b0, req.a} - {1'b0, req.b};
        case (req.op)
            MOD_ADD:
            begin
                if (sum >= {1'b0, cap})
                    wide = sum - {1'b0, cap};
                else
                    wide = sum;
            end
            MOD_SUB:
            begin
                if (diff[CAP_W])
                    wide = diff + {1'b0, cap};
                else
                    wide = diff;
            end
            default: wide = sum;
        endcase
        res = wide[ADDR_W-1:0];
    end

endmodule

`default_nettype wire

// ===== src/shr_store.sv =====
// Sample store: one write port, one registered read port.
`default_nettype none

module shr_store
    import shr_pkg::*;
(
    input  logic                       clk,
    input  mem_wr_t                    wr,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
